@@ design/set_assoc_lru_cache_model_core_macros.svh @@
// Assertion macros for the set-associative LRU cache core.
// Included by the top level; relies on i_clk and i_rst_n in the including scope.
`ifndef SET_ASSOC_LRU_CACHE_MODEL_CORE_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SALC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SALC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/salc_pkg.sv @@
// Shared types and constants for the set-associative LRU cache core.
// No dependencies; used by the controller, the datapath and the top level.
package salc_pkg;

    localparam int ADDR_W = 32;
    localparam int MISS_W = 32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;      // capture the input word and start the set read
        logic commit;      // update the set, the counter and the result register
        logic clear_step;  // write one cleared metadata row
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;  // the current clearing write is the last row
        logic out_stall;   // result register full and not taken this cycle
    } t_dp_status;

endpackage

@@ design/salc_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/salc_ctrl.sv @@
// Controller for the cache core: clearing pass, accept, lookup and commit.
// Depends on salc_pkg for the command and status structs.
module salc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    output salc_pkg::t_ctrl_cmd   o_cmd,
    input  salc_pkg::t_dp_status  i_status
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_LOOK  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_LOOK;
                end
            end
            S_LOOK: begin
                // The set row is on the RAM outputs; wait only for room in the result register.
                if (!i_status.out_stall) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ design/salc_dp.sv @@
// Datapath for the cache core: tag and metadata RAMs, way compare, LRU update,
// miss counter and result register. Depends on salc_pkg and salc_ram.
module salc_dp #(
    parameter int LINE_SIZE = 64,
    parameter int SETS      = 32,
    parameter int WAYS      = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  salc_pkg::t_ctrl_cmd          i_cmd,
    output salc_pkg::t_dp_status         o_status,
    input  logic [salc_pkg::ADDR_W-1:0]  i_byte_address,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_hit,
    output logic                         o_evicted,
    output logic [salc_pkg::MISS_W-1:0]  o_miss_total
);

    localparam int OFFSET_W = $clog2(LINE_SIZE);
    localparam int SET_BITS = $clog2(SETS);
    localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int TAG_W    = salc_pkg::ADDR_W - OFFSET_W - SET_BITS;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RANK_W   = WAY_W;
    localparam int META_W   = WAYS * (1 + RANK_W);
    localparam int TROW_W   = WAYS * TAG_W;

    logic [salc_pkg::ADDR_W-1:0] w_line;
    logic [SET_W-1:0]            w_in_set;
    logic [TAG_W-1:0]            w_in_tag;

    logic [SET_W-1:0]  r_set;
    logic [TAG_W-1:0]  r_tag;
    logic [SET_W-1:0]  r_clr_idx;
    logic [salc_pkg::MISS_W-1:0] r_miss;
    logic              r_out_valid;
    logic              r_hit;
    logic              r_evicted;

    logic [META_W-1:0] w_meta_rd;
    logic [TROW_W-1:0] w_tag_rd;
    logic [META_W-1:0] w_meta_new;
    logic [TROW_W-1:0] w_tag_new;
    logic [META_W-1:0] w_meta_wdata;
    logic [SET_W-1:0]  w_meta_waddr;
    logic [SET_W-1:0]  w_raddr;
    logic              w_meta_we;
    logic              w_tag_we;

    logic [WAYS-1:0]   w_valid;
    logic [RANK_W-1:0] w_rank [WAYS];
    logic [TAG_W-1:0]  w_tags [WAYS];

    logic              w_hit_found;
    logic [WAY_W-1:0]  w_hit_way;
    logic [RANK_W-1:0] w_hit_rank;
    logic              w_empty_found;
    logic [WAY_W-1:0]  w_empty_way;
    logic [WAY_W-1:0]  w_victim_way;
    logic [WAY_W-1:0]  w_slot;

    // Line offset, set and tag are plain bit fields because all sizes are powers of two.
    assign w_line   = i_byte_address >> OFFSET_W;
    assign w_in_set = SET_W'(w_line & salc_pkg::ADDR_W'(SETS - 1));
    assign w_in_tag = TAG_W'(w_line >> SET_BITS);

    assign w_raddr = i_cmd.accept ? w_in_set : r_set;

    salc_ram #(
        .WIDTH (META_W),
        .DEPTH (SETS)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (w_meta_we),
        .i_waddr (w_meta_waddr),
        .i_wdata (w_meta_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_meta_rd)
    );

    salc_ram #(
        .WIDTH (TROW_W),
        .DEPTH (SETS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (w_tag_we),
        .i_waddr (r_set),
        .i_wdata (w_tag_new),
        .i_raddr (w_raddr),
        .o_rdata (w_tag_rd)
    );

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            w_valid[w] = w_meta_rd[w];
            w_rank[w]  = w_meta_rd[WAYS + w*RANK_W +: RANK_W];
            w_tags[w]  = w_tag_rd[w*TAG_W +: TAG_W];
        end
    end

    // Way search. In a full set the ranks are exactly 0..WAYS-1, so the least
    // recent way is the one holding the top rank.
    always_comb begin
        w_hit_found   = 1'b0;
        w_hit_way     = '0;
        w_hit_rank    = '0;
        w_empty_found = 1'b0;
        w_empty_way   = '0;
        w_victim_way  = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (w_valid[w] && (w_tags[w] == r_tag) && !w_hit_found) begin
                w_hit_found = 1'b1;
                w_hit_way   = WAY_W'(w);
                w_hit_rank  = w_rank[w];
            end
            if (!w_valid[w] && !w_empty_found) begin
                w_empty_found = 1'b1;
                w_empty_way   = WAY_W'(w);
            end
            if (w_valid[w] && (w_rank[w] == RANK_W'(WAYS - 1))) begin
                w_victim_way = WAY_W'(w);
            end
        end
    end

    assign w_slot = w_empty_found ? w_empty_way : w_victim_way;

    always_comb begin
        w_meta_new = w_meta_rd;
        w_tag_new  = w_tag_rd;
        for (int w = 0; w < WAYS; w++) begin
            if (w_hit_found) begin
                if (WAY_W'(w) == w_hit_way) begin
                    w_meta_new[WAYS + w*RANK_W +: RANK_W] = '0;
                end else if (w_valid[w] && (w_rank[w] < w_hit_rank)) begin
                    w_meta_new[WAYS + w*RANK_W +: RANK_W] = w_rank[w] + RANK_W'(1);
                end
            end else begin
                if (WAY_W'(w) == w_slot) begin
                    w_meta_new[w]                         = 1'b1;
                    w_meta_new[WAYS + w*RANK_W +: RANK_W] = '0;
                    w_tag_new[w*TAG_W +: TAG_W]           = r_tag;
                end else if (w_valid[w]) begin
                    w_meta_new[WAYS + w*RANK_W +: RANK_W] = w_rank[w] + RANK_W'(1);
                end
            end
        end
    end

    assign w_meta_we    = i_cmd.clear_step | i_cmd.commit;
    assign w_meta_waddr = i_cmd.clear_step ? r_clr_idx : r_set;
    assign w_meta_wdata = i_cmd.clear_step ? '0 : w_meta_new;
    assign w_tag_we     = i_cmd.commit & ~w_hit_found;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_set <= w_in_set;
            r_tag <= w_in_tag;
        end
        if (i_cmd.commit) begin
            r_hit     <= w_hit_found;
            r_evicted <= ~w_hit_found & ~w_empty_found;
        end
    end

    // The counter drives the result directly: it changes only when a new result is loaded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx   <= '0;
            r_miss      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_step) begin
                r_clr_idx <= (r_clr_idx == SET_W'(SETS - 1)) ? '0 : r_clr_idx + SET_W'(1);
            end
            if (i_cmd.commit && !w_hit_found && (r_miss != '1)) begin
                r_miss <= r_miss + salc_pkg::MISS_W'(1);
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.clear_last = (r_clr_idx == SET_W'(SETS - 1));
    assign o_status.out_stall  = r_out_valid & ~i_ready;

    assign o_valid      = r_out_valid;
    assign o_hit        = r_hit;
    assign o_evicted    = r_evicted;
    assign o_miss_total = r_miss;

endmodule

@@ design/set_assoc_lru_cache_model_core.sv @@
// Top level of the set-associative LRU cache tag model.
// Depends on salc_pkg, salc_ctrl, salc_dp (with salc_ram) and the assertion macro header.
//
//   channel  direction  handshake          payload
//   input    in         i_valid / o_ready  i_byte_address
//   result   out        o_valid / i_ready  o_hit, o_evicted, o_miss_total
//
// For each word the set row is first read from the tag and metadata RAMs; the ways
// are then compared and the row is written back.
// After reset a clearing pass writes SETS metadata rows, one a cycle, before the
// first word is taken.
// A result waits in an output register; the next word is taken meanwhile, and its
// lookup holds until that register is free.
`include "set_assoc_lru_cache_model_core_macros.svh"

module set_assoc_lru_cache_model_core #(
    parameter int LINE_SIZE = 64,
    parameter int SETS      = 32,
    parameter int WAYS      = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [salc_pkg::ADDR_W-1:0]  i_byte_address,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_hit,
    output logic                         o_evicted,
    output logic [salc_pkg::MISS_W-1:0]  o_miss_total
);

    salc_pkg::t_ctrl_cmd  w_cmd;
    salc_pkg::t_dp_status w_status;

    salc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_cmd    (w_cmd),
        .i_status (w_status)
    );

    salc_dp #(
        .LINE_SIZE (LINE_SIZE),
        .SETS      (SETS),
        .WAYS      (WAYS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_byte_address (i_byte_address),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_hit          (o_hit),
        .o_evicted      (o_evicted),
        .o_miss_total   (o_miss_total)
    );

    `SALC_ASSERT_IMPL(a_cmd_exclusive, 1'b1, $onehot0(w_cmd), "overlapping controller commands")
    `SALC_ASSERT_NEXT(a_commit_shows, w_cmd.commit, o_valid, "commit did not present a result")
    `SALC_ASSERT_NEXT(a_accept_busy, w_cmd.accept, !o_ready, "input ready during a lookup")
    `SALC_ASSERT_IMPL(a_hit_no_evict, o_valid, !(o_hit && o_evicted), "a hit reported an eviction")

endmodule

@@ sim/tb_set_assoc_lru_cache_model_core.sv @@
// Testbench for set_assoc_lru_cache_model_core: drives byte address words, predicts
// hit, eviction and miss count with a tag and LRU model of its own, and checks each result.
// Depends on salc_pkg and the set_assoc_lru_cache_model_core RTL.
`timescale 1ns / 1ps

module tb_set_assoc_lru_cache_model_core;

    localparam int LINE_SIZE   = 64;
    localparam int SETS        = 32;
    localparam int WAYS        = 4;
    localparam int OFFSET_W    = $clog2(LINE_SIZE);
    localparam int SET_W       = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int TAG_W       = salc_pkg::ADDR_W - OFFSET_W - $clog2(SETS);
    localparam int AGE_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RANDOM_WORDS = 1030;
    localparam int HOT_TAGS    = 6;
    localparam int HOT_SETS    = 4;
    localparam int CYCLE_LIMIT = 500000;
    localparam int N_PROBES    = 21;

    typedef struct packed {
        logic                        hit;
        logic                        evicted;
        logic [salc_pkg::MISS_W-1:0] miss_total;
    } t_access_result;

    typedef struct packed {
        logic [salc_pkg::ADDR_W-1:0] addr;
        logic                        typed;
        logic                        hit;
        logic                        evicted;
        logic [salc_pkg::MISS_W-1:0] miss_total;
    } t_probe;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_ready;
    logic [salc_pkg::ADDR_W-1:0]  i_byte_address;
    logic                         o_valid;
    logic                         i_ready;
    logic                         o_hit;
    logic                         o_evicted;
    logic [salc_pkg::MISS_W-1:0]  o_miss_total;

    // Shadow copy of the tag store and its recency ranks; rank 0 is the most recent.
    logic [TAG_W-1:0]            line_tag   [SETS][WAYS];
    logic                        line_valid [SETS][WAYS];
    logic [AGE_W-1:0]            line_age   [SETS][WAYS];
    logic [salc_pkg::MISS_W-1:0] miss_count;

    t_access_result pending_results [$];
    int             fail_count;
    int             results_taken;
    int             cycle_count;

    logic [TAG_W-1:0] hot_tag [HOT_TAGS];
    logic [SET_W-1:0] hot_set [HOT_SETS];

    // Rows with typed = 1 carry results that follow directly from a fresh cache.
    t_probe probe_table [N_PROBES] = '{
        '{32'h0000_0000, 1'b1, 1'b0, 1'b0, 32'd1},
        '{32'h0000_003F, 1'b1, 1'b1, 1'b0, 32'd1},
        '{32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 32'd2},
        '{32'hFFFF_FFC0, 1'b1, 1'b1, 1'b0, 32'd2},
        '{32'h0000_0040, 1'b1, 1'b0, 1'b0, 32'd3},
        '{32'h0000_0800, 1'b1, 1'b0, 1'b0, 32'd4},
        '{32'h0000_1000, 1'b1, 1'b0, 1'b0, 32'd5},
        '{32'h0000_1800, 1'b1, 1'b0, 1'b0, 32'd6},
        '{32'h0000_2000, 1'b1, 1'b0, 1'b1, 32'd7},
        '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'd0},
        '{32'h0000_1000, 1'b0, 1'b0, 1'b0, 32'd0},
        '{32'h0000_0800, 1'b0, 1'b0, 1'b0, 32'd0},
        '{32'h0000_1800, 1'b0, 1'b0, 1'b0, 32'd0},
        '{32'hFFFF_F800, 1'b0, 1'b0, 1'b0, 32'd0},
        '{32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 32'd0},
        '{32'h8000_0000, 1'b0, 1'b0, 1'b0, 32'd0},
        '{32'h0000_1000, 1'b0, 1'b0, 1'b0, 32'd0},
        '{32'hFFFF_F83F, 1'b0, 1'b0, 1'b0, 32'd0},
        '{32'h5555_5555, 1'b0, 1'b0, 1'b0, 32'd0},
        '{32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0, 32'd0},
        '{32'h0000_2000, 1'b0, 1'b0, 1'b0, 32'd0}
    };

    set_assoc_lru_cache_model_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_byte_address (i_byte_address),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_hit          (o_hit),
        .o_evicted      (o_evicted),
        .o_miss_total   (o_miss_total)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Looks up one address in the shadow cache and applies the LRU update.
    function automatic t_access_result access_line(input logic [salc_pkg::ADDR_W-1:0] addr);
        logic [salc_pkg::ADDR_W-1:0] line_no;
        int unsigned                 set_idx;
        logic [TAG_W-1:0]            tag;
        int                          found;
        int                          empty;
        int                          victim;
        int                          slot;
        logic [AGE_W-1:0]            oldest;
        logic [AGE_W-1:0]            hit_age;
        t_access_result              res;
        line_no = addr / LINE_SIZE;
        set_idx = line_no % SETS;
        tag     = TAG_W'(line_no / SETS);
        found   = -1;
        empty   = -1;
        victim  = -1;
        oldest  = '0;
        res     = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (line_valid[set_idx][w]) begin
                if (found < 0 && line_tag[set_idx][w] == tag)
                    found = w;
                if (victim < 0 || line_age[set_idx][w] > oldest) begin
                    victim = w;
                    oldest = line_age[set_idx][w];
                end
            end else if (empty < 0) begin
                empty = w;
            end
        end
        if (found >= 0) begin
            hit_age = line_age[set_idx][found];
            res.hit = 1'b1;
            for (int w = 0; w < WAYS; w++)
                if (line_valid[set_idx][w] && line_age[set_idx][w] < hit_age)
                    line_age[set_idx][w] = line_age[set_idx][w] + 1'b1;
            line_age[set_idx][found] = '0;
        end else begin
            if (miss_count != '1)
                miss_count = miss_count + 1'b1;
            if (empty >= 0) begin
                slot = empty;
            end else begin
                slot = victim;
                res.evicted = 1'b1;
            end
            for (int w = 0; w < WAYS; w++)
                if (w != slot && line_valid[set_idx][w])
                    line_age[set_idx][w] = line_age[set_idx][w] + 1'b1;
            line_tag[set_idx][slot]   = tag;
            line_valid[set_idx][slot] = 1'b1;
            line_age[set_idx][slot]   = '0;
        end
        res.miss_total = miss_count;
        return res;
    endfunction

    // Mostly no gap, some short ones, a few long ones.
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Most addresses come from a small working set so that lines hit and age out.
    function automatic logic [salc_pkg::ADDR_W-1:0] pick_address();
        logic [OFFSET_W-1:0] offset;
        offset = OFFSET_W'($urandom);
        if ($urandom_range(0, 9) < 7)
            return {hot_tag[$urandom_range(0, HOT_TAGS - 1)],
                    hot_set[$urandom_range(0, HOT_SETS - 1)], offset};
        else
            return $urandom;
    endfunction

    task automatic send_word(input logic [salc_pkg::ADDR_W-1:0] addr,
                             input logic typed, input t_access_result typed_res);
        t_access_result predicted;
        i_valid        <= 1'b1;
        i_byte_address <= addr;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        predicted = access_line(addr);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic word_gap(input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin : word_source
        t_access_result typed_res;
        logic           quiet;
        for (int s = 0; s < SETS; s++)
            for (int w = 0; w < WAYS; w++) begin
                line_tag[s][w]   = '0;
                line_valid[s][w] = 1'b0;
                line_age[s][w]   = '0;
            end
        miss_count     = '0;
        fail_count     = 0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_byte_address = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < N_PROBES; p++) begin
            typed_res = '{probe_table[p].hit, probe_table[p].evicted,
                          probe_table[p].miss_total};
            send_word(probe_table[p].addr, probe_table[p].typed, typed_res);
            word_gap(idle_len());
        end

        for (int t = 0; t < HOT_TAGS; t++)
            hot_tag[t] = TAG_W'($urandom);
        hot_set[0] = '0;
        hot_set[1] = '1;
        for (int s = 2; s < HOT_SETS; s++)
            hot_set[s] = SET_W'($urandom);

        quiet = 1'b0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            send_word(pick_address(), 1'b0, '0);
            if (n % 64 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (n == RANDOM_WORDS / 2) begin
                // Let the pipeline drain completely before going on.
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (pending_results.size() != 0)
                    @(posedge i_clk);
            end else begin
                word_gap(quiet ? 0 : idle_len());
            end
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin : result_sink
        int   run_len;
        int   stall_len;
        logic long_hold_done;
        long_hold_done = 1'b0;
        i_ready        = 1'b0;
        repeat (3) @(posedge i_clk);
        forever begin
            i_ready <= 1'b1;
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 8);
            repeat (run_len) @(posedge i_clk);
            // One long hold-off lets the block fill and stall its input.
            if (!long_hold_done && results_taken >= 200) begin
                long_hold_done = 1'b1;
                stall_len = 400;
            end else begin
                stall_len = idle_len();
            end
            if (stall_len > 0) begin
                i_ready <= 1'b0;
                repeat (stall_len) @(posedge i_clk);
            end
        end
    end

    initial results_taken = 0;

    always @(posedge i_clk) begin
        t_access_result want;
        if (i_rst_n && o_valid && i_ready) begin
            results_taken = results_taken + 1;
            if (pending_results.size() == 0) begin
                $error("unexpected result word: hit %0d evicted %0d miss_total %0d",
                       o_hit, o_evicted, o_miss_total);
                fail_count = fail_count + 1;
            end else begin
                want = pending_results.pop_front();
                if (o_hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, o_hit);
                    fail_count = fail_count + 1;
                end
                if (o_evicted !== want.evicted) begin
                    $error("evicted: expected %0d, got %0d", want.evicted, o_evicted);
                    fail_count = fail_count + 1;
                end
                if (o_miss_total !== want.miss_total) begin
                    $error("miss_total: expected %0d, got %0d",
                           want.miss_total, o_miss_total);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    initial cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule

@@ files.f @@
+incdir+design
design/salc_pkg.sv
design/salc_ram.sv
design/salc_ctrl.sv
design/salc_dp.sv
design/set_assoc_lru_cache_model_core.sv
sim/tb_set_assoc_lru_cache_model_core.sv
